// ===== design/npl_pkg.sv =====
// ----------------------------------------------------------------------------
// npl_pkg: shared types and constants for the nearest point lookup
// Field widths, action codes, the table entry layout and the pipeline side
// information that travels with each entry through the distance unit.
// ----------------------------------------------------------------------------
package npl_pkg;

  localparam int SLOT_W  = 6;
  localparam int TAG_W   = 16;
  localparam int COORD_W = 24;
  localparam int LIMIT_W = 23;
  // coordinate difference, its square and the sum of three squares
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int LSQ_W   = 2 * LIMIT_W;

  localparam int MAX_ENTRIES_DEF = 64;

  // one meter is 1024 units; the default limit is a thousand meters
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000 * 1024);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } probe_t;

  // read issue marker, aligned with the registered RAM output
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [SLOT_W-1:0] slot;
  } issue_t;

  // side information carried through the distance pipeline
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
  } side_t;

  // running best match
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
  } best_t;

endpackage

// ===== design/npl_in_if.sv =====
// ----------------------------------------------------------------------------
// npl_in_if: request channel of the nearest point lookup
// Carries one load or query word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface npl_in_if;
  import npl_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [SLOT_W-1:0]         entry_slot;
  logic [TAG_W-1:0]          entry_tag;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;

  modport source (
    output valid, action, entry_slot, entry_tag, pos_x, pos_y, pos_z,
    input  ready
  );

  modport sink (
    input  valid, action, entry_slot, entry_tag, pos_x, pos_y, pos_z,
    output ready
  );

endinterface

// ===== design/npl_out_if.sv =====
// ----------------------------------------------------------------------------
// npl_out_if: result channel of the nearest point lookup
// Carries one match word per query with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface npl_out_if;
  import npl_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] match_slot;
  logic [TAG_W-1:0]  match_tag;

  modport source (
    output valid, found, match_slot, match_tag,
    input  ready
  );

  modport sink (
    input  valid, found, match_slot, match_tag,
    output ready
  );

endinterface

// ===== design/npl_ram.sv =====
// ----------------------------------------------------------------------------
// npl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module npl_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/npl_dist.sv =====
// ----------------------------------------------------------------------------
// npl_dist: squared distance pipeline
// Takes one table entry per cycle and returns its squared Euclidean distance
// to the probe point through registered stages: difference, square, sum.
// ----------------------------------------------------------------------------
module npl_dist (
  input  logic                clk,
  input  logic                rst,
  input  npl_pkg::probe_t     probe,
  input  npl_pkg::issue_t     side_in,
  input  npl_pkg::entry_t     entry,
  output npl_pkg::side_t      side_out,
  output logic [npl_pkg::DIST_W-1:0] d2
);
  import npl_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [DIFF_W-1:0]        ax, ay, az;
  logic [SQ_W-1:0]          sx, sy, sz;
  side_t                    s1, s2;

  // signed differences
  assign dx = DIFF_W'(probe.x) - DIFF_W'(entry.px);
  assign dy = DIFF_W'(probe.y) - DIFF_W'(entry.py);
  assign dz = DIFF_W'(probe.z) - DIFF_W'(entry.pz);

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid       <= 1'b0;
      s2.valid       <= 1'b0;
      side_out.valid <= 1'b0;
    end else begin
      s1.valid       <= side_in.valid;
      s2.valid       <= s1.valid;
      side_out.valid <= s2.valid;
    end
  end

  // stage payload: magnitude, square, sum
  always_ff @(posedge clk) begin
    ax <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    az <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    s1.last <= side_in.last;
    s1.slot <= side_in.slot;
    s1.tag  <= entry.tag;

    sx <= ax * ax;
    sy <= ay * ay;
    sz <= az * az;
    s2.last <= s1.last;
    s2.slot <= s1.slot;
    s2.tag  <= s1.tag;

    d2 <= DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sz);
    side_out.last <= s2.last;
    side_out.slot <= s2.slot;
    side_out.tag  <= s2.tag;
  end

endmodule

// ===== design/npl_best.sv =====
// ----------------------------------------------------------------------------
// npl_best: running minimum tracker
// Starts from the squared limit and keeps each entry that comes in strictly
// below the best distance seen so far, so a tie keeps the earlier entry.
// ----------------------------------------------------------------------------
module npl_best (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [npl_pkg::LIMIT_W-1:0] limit,
  input  npl_pkg::side_t              side,
  input  logic [npl_pkg::DIST_W-1:0]  d2,
  output npl_pkg::best_t              best,
  output logic                        done
);
  import npl_pkg::*;

  logic [LSQ_W-1:0]  limit_sq;
  logic [DIST_W-1:0] best_d2;
  logic              better;

  assign limit_sq = limit * limit;
  assign better   = side.valid && (d2 < best_d2);

  // scan end marker
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side.valid && side.last;
    end
  end

  // seed with the limit, then take strictly smaller distances only
  always_ff @(posedge clk) begin
    if (rst) begin
      best.hit <= 1'b0;
    end else if (start) begin
      best.hit <= 1'b0;
    end else if (better) begin
      best.hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      best_d2   <= DIST_W'(limit_sq);
      best.slot <= '0;
      best.tag  <= '0;
    end else if (better) begin
      best_d2   <= d2;
      best.slot <= side.slot;
      best.tag  <= side.tag;
    end
  end

endmodule

// ===== design/nearest_point_lookup_top.sv =====
// ----------------------------------------------------------------------------
// nearest_point_lookup_top: nearest point search over a reference table
// Holds up to MAX_ENTRIES 3-D points with tags and finds the nearest one to a
// query point, within a programmable distance limit.
// ----------------------------------------------------------------------------
// Usage:
//   req carries load and query words. A load writes one table entry and sets
//   the entry count to its slot plus one; it gives no result. A load to a
//   slot beyond the table is dropped.
//   A query gives exactly one word on rsp: found, slot and tag of the first
//   entry strictly nearest and strictly inside distance_limit, else zeros.
//   The table is read one entry per cycle through a single read port into a
//   shared squared-distance pipeline (difference, square, sum) and a
//   running-minimum compare; req is not ready while a query runs, and an
//   empty table skips the scan.
//   cfg_wr_en/cfg_wr_data set distance_limit; write it only while idle.
//   Reset clears the entry count and the result valid flag and sets the
//   limit to 1000 m. The table itself is not cleared.
//   The result stays in an output register while rsp stalls; loads and the
//   next query's scan go ahead, and a query result waits for that register.
// ----------------------------------------------------------------------------
module nearest_point_lookup_top #(
  parameter int MAX_ENTRIES = npl_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [npl_pkg::LIMIT_W-1:0] cfg_wr_data,
  npl_in_if.sink                      req,
  npl_out_if.source                   rsp
);
  import npl_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state, state_next;
  logic [LIMIT_W-1:0] distance_limit;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   issue_cnt;
  logic               issue_last;
  probe_t             probe;
  issue_t             rd_side;
  entry_t             wr_entry, rd_entry;
  logic               accept, is_load, slot_ok, ram_we, start;
  logic               out_free;
  side_t              dist_side;
  logic [DIST_W-1:0]  dist_d2;
  best_t              best;
  logic               best_done;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_load   = (req.action == ACT_LOAD);
  assign slot_ok   = 32'(req.entry_slot) < 32'(MAX_ENTRIES);
  assign ram_we    = accept && is_load && slot_ok;
  assign start     = accept && !is_load;
  assign out_free  = !rsp.valid || rsp.ready;
  assign issue_last = (issue_cnt + CNT_W'(1)) == entry_count;

  assign wr_entry.tag = req.entry_tag;
  assign wr_entry.px  = req.pos_x;
  assign wr_entry.py  = req.pos_y;
  assign wr_entry.pz  = req.pos_z;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      distance_limit <= cfg_wr_data;
    end
  end

  // entry count follows the last load
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ram_we) begin
      entry_count <= CNT_W'(32'(req.entry_slot) + 32'd1);
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (entry_count == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (best_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // advance the read index during the scan
  always_ff @(posedge clk) begin
    if (start) begin
      issue_cnt <= '0;
    end else if (state == ST_SCAN) begin
      issue_cnt <= issue_cnt + CNT_W'(1);
    end
  end

  // hold the probe point for the whole scan
  always_ff @(posedge clk) begin
    if (start) begin
      probe.x <= req.pos_x;
      probe.y <= req.pos_y;
      probe.z <= req.pos_z;
    end
  end

  // align the issue marker with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_side.valid <= 1'b0;
    end else begin
      rd_side.valid <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    rd_side.last <= issue_last;
    rd_side.slot <= SLOT_W'(issue_cnt);
  end

  npl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(req.entry_slot)),
    .wdata (wr_entry),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  npl_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .probe    (probe),
    .side_in  (rd_side),
    .entry    (rd_entry),
    .side_out (dist_side),
    .d2       (dist_d2)
  );

  npl_best u_best (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .limit (distance_limit),
    .side  (dist_side),
    .d2    (dist_d2),
    .best  (best),
    .done  (best_done)
  );

  // result register: load when free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      rsp.found      <= best.hit;
      rsp.match_slot <= best.slot;
      rsp.match_tag  <= best.tag;
    end
  end

endmodule
